/* design/lpb_pkg.sv */
`timescale 1ns / 1ps

package lpb_pkg;

   // Item kinds
   localparam logic REQ_TICK   = 1'b0;
   localparam logic REQ_BUTTON = 1'b1;

   // Field widths
   localparam int PIN_W    = 4;
   localparam int TIME_W   = 32;
   localparam int PERIOD_W = 10;
   localparam int LOCK_W   = 16;
   localparam int LED_W    = 4;
   localparam int SCHEME_W = 2;
   localparam int PHASE_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Function pins
   localparam logic [PIN_W-1:0] PIN_PREV   = 4'd11;
   localparam logic [PIN_W-1:0] PIN_NEXT   = 4'd9;
   localparam logic [PIN_W-1:0] PIN_FASTER = 4'd8;
   localparam logic [PIN_W-1:0] PIN_SLOWER = 4'd6;
   localparam logic [PIN_W-1:0] PIN_ONOFF  = 4'd15;

   // Schemes
   localparam logic [SCHEME_W-1:0] SCHEME_TOGGLE = 2'd0;
   localparam logic [SCHEME_W-1:0] SCHEME_CHASE  = 2'd1;
   localparam logic [SCHEME_W-1:0] SCHEME_PAIRS  = 2'd2;
   localparam logic [SCHEME_W-1:0] SCHEME_LAST   = 2'd2;

   // LED patterns
   localparam logic [LED_W-1:0] LEDS_OFF    = 4'h0;
   localparam logic [LED_W-1:0] LEDS_ALL    = 4'hF;
   localparam logic [LED_W-1:0] LEDS_PAIR_A = 4'h5;
   localparam logic [LED_W-1:0] LEDS_PAIR_B = 4'hA;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_MIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_MAX  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_STEP = 2'd3;

   // Reset values
   localparam logic [LOCK_W-1:0]   LOCKOUT_RST     = 16'd150;
   localparam logic [PERIOD_W-1:0] PERIOD_MIN_RST  = 10'd50;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX_RST  = 10'd1000;
   localparam logic [PERIOD_W-1:0] PERIOD_STEP_RST = 10'd50;
   localparam logic [PERIOD_W-1:0] PERIOD_RST      = 10'd200;

   typedef struct packed {
      logic             req_type;
      logic [PIN_W-1:0] pin;
   } req_item_type;

   typedef struct packed {
      logic [LED_W-1:0]    leds;
      logic                enabled;
      logic [SCHEME_W-1:0] scheme;
      logic [PERIOD_W-1:0] period_ms;
   } rsp_item_type;

   // Timestamp write-back
   typedef struct packed {
      logic              en;
      logic [PIN_W-1:0]  pin;
      logic [TIME_W-1:0] stamp;
   } stamp_wr_type;

endpackage

/* design/lpb_stamp_mem.sv */
`timescale 1ns / 1ps

// Per-pin press timestamps: one synchronous read, one write, write forwarding
module lpb_stamp_mem #(
   parameter int NUM_PINS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [lpb_pkg::PIN_W-1:0]   rd_pin,
   input  lpb_pkg::stamp_wr_type       wr,
   output logic [lpb_pkg::TIME_W-1:0]  rd_stamp
);
   import lpb_pkg::*;

   localparam int AW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

   logic [TIME_W-1:0] mem [NUM_PINS];
   logic [NUM_PINS-1:0] vld_ff;
   logic [NUM_PINS-1:0] vld_in;

   logic [TIME_W-1:0] rd_data_ff;
   logic              rd_vld_ff;
   logic [AW-1:0]     rd_addr_ff;

   logic              fwd_vld_ff;
   logic [AW-1:0]     fwd_addr_ff;
   logic [TIME_W-1:0] fwd_data_ff;

   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;

   assign rd_addr = rd_pin[AW-1:0];
   assign wr_addr = wr.pin[AW-1:0];

   // Storage and registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.stamp;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // Written flags; an unwritten entry reads as zero
   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
         if (wr.en) begin
            fwd_vld_ff <= 1'b1;
         end
      end
   end

   // Most recent write, for a read issued in the same cycle as it
   always_ff @(posedge clock) begin
      if (wr.en) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr.stamp;
      end
   end

   always_comb begin
      priority if (fwd_vld_ff && (fwd_addr_ff == rd_addr_ff)) begin
         rd_stamp = fwd_data_ff;
      end else if (rd_vld_ff) begin
         rd_stamp = rd_data_ff;
      end else begin
         rd_stamp = '0;
      end
   end

`ifndef ASSERT_OFF
   a_wr_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> vld_ff[$past(wr_addr)])
      else $error("written entry not flagged");
   a_fwd_after_write: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> (fwd_vld_ff && fwd_data_ff == $past(wr.stamp)))
      else $error("forwarding register missed a write");
   a_rd_of_unwritten: assert property (@(posedge clock) disable iff (reset)
      (rd_en && !vld_ff[rd_addr] && !wr.en) |=>
         (!rd_vld_ff || (fwd_vld_ff && fwd_addr_ff == rd_addr_ff)))
      else $error("unwritten entry read as valid");
`endif

endmodule

/* design/led_pattern_blinker_with_buttons_top.sv */
`timescale 1ns / 1ps
// Accepted transactions enter the stage-1 register, then the output register.
// One transaction per cycle unless the result side stalls. The timestamp memory
// has one read port, read at acceptance; the previous item's write is forwarded.
// Reset (synchronous): registers to 150/50/1000/50, time and timestamps to 0,
// scheme 0, phase 0, blinking on, period 200, LEDs off, pipeline empty.
module led_pattern_blinker_with_buttons_top #(
   parameter int NUM_PINS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  lpb_pkg::req_item_type           req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output lpb_pkg::rsp_item_type           rsp_data,
   input  logic                            csr_we,
   input  logic [lpb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lpb_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import lpb_pkg::*;

   // Configuration
   logic [LOCK_W-1:0]   lockout_ff;
   logic [PERIOD_W-1:0] pmin_ff, pmax_ff, pstep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff <= LOCKOUT_RST;
         pmin_ff    <= PERIOD_MIN_RST;
         pmax_ff    <= PERIOD_MAX_RST;
         pstep_ff   <= PERIOD_STEP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOCKOUT:     lockout_ff <= csr_wdata;
            CSR_PERIOD_MIN:  pmin_ff    <= csr_wdata[PERIOD_W-1:0];
            CSR_PERIOD_MAX:  pmax_ff    <= csr_wdata[PERIOD_W-1:0];
            CSR_PERIOD_STEP: pstep_ff   <= csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline control
   logic         s1_vld_ff;
   req_item_type s1_item_ff;
   logic         out_vld_ff;
   rsp_item_type out_item_ff;
   logic         s1_fire;
   logic         req_take;

   assign s1_fire   = s1_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !s1_fire;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_item_ff;

   // Block state
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [TIME_W-1:0]   last_step_ff, last_step_in;
   logic [SCHEME_W-1:0] scheme_ff, scheme_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic                on_ff, on_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [LED_W-1:0]    leds_ff, leds_in;

   logic [TIME_W-1:0] stamp;
   stamp_wr_type      stamp_wr;

   lpb_stamp_mem #(
      .NUM_PINS (NUM_PINS)
   ) u_stamp_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_take),
      .rd_pin   (req_data.pin),
      .wr       (stamp_wr),
      .rd_stamp (stamp)
   );

   // Item evaluation: button effect, then the blink step
   logic                pin_ok;
   logic                btn_taken;
   logic [TIME_W-1:0]   press_gap;
   logic [TIME_W-1:0]   step_gap;
   logic [PERIOD_W-1:0] faster_p;
   logic [PERIOD_W:0]   slower_sum;
   logic [SCHEME_W-1:0] scheme_b;
   logic [PHASE_W-1:0]  phase_b;
   logic                on_b;
   logic [PERIOD_W-1:0] period_b;
   logic [LED_W-1:0]    leds_b;

   always_comb begin
      pin_ok    = {1'b0, s1_item_ff.pin} < (PIN_W + 1)'(NUM_PINS);
      press_gap = time_ff - stamp;
      btn_taken = (s1_item_ff.req_type == REQ_BUTTON) && pin_ok &&
                  (press_gap >= {{(TIME_W - LOCK_W){1'b0}}, lockout_ff});

      time_in = (s1_item_ff.req_type == REQ_TICK) ? time_ff + 1'b1 : time_ff;

      stamp_wr.en    = s1_fire && btn_taken;
      stamp_wr.pin   = s1_item_ff.pin;
      stamp_wr.stamp = time_ff;

      faster_p = (period_ff > pstep_ff) ? period_ff - pstep_ff : '0;
      if (faster_p < pmin_ff) begin
         faster_p = pmin_ff;
      end
      slower_sum = {1'b0, period_ff} + {1'b0, pstep_ff};

      scheme_b = scheme_ff;
      phase_b  = phase_ff;
      on_b     = on_ff;
      period_b = period_ff;
      leds_b   = leds_ff;
      if (btn_taken) begin
         unique case (s1_item_ff.pin)
            PIN_PREV: begin
               scheme_b = (scheme_ff == SCHEME_TOGGLE) ? SCHEME_LAST : scheme_ff - 1'b1;
               phase_b  = '0;
               leds_b   = LEDS_OFF;
            end
            PIN_NEXT: begin
               scheme_b = (scheme_ff == SCHEME_LAST) ? SCHEME_TOGGLE : scheme_ff + 1'b1;
               phase_b  = '0;
               leds_b   = LEDS_OFF;
            end
            PIN_FASTER: begin
               if (period_ff > pmin_ff) begin
                  period_b = faster_p;
               end
            end
            PIN_SLOWER: begin
               if (period_ff < pmax_ff) begin
                  period_b = (slower_sum > {1'b0, pmax_ff}) ? pmax_ff
                                                             : slower_sum[PERIOD_W-1:0];
               end
            end
            PIN_ONOFF: begin
               on_b = !on_ff;
               if (on_ff) begin
                  leds_b = LEDS_OFF;
               end
            end
            default: ;
         endcase
      end

      // Blink step at the item's time
      step_gap     = time_in - last_step_ff;
      scheme_in    = scheme_b;
      on_in        = on_b;
      period_in    = period_b;
      phase_in     = phase_b;
      leds_in      = leds_b;
      last_step_in = last_step_ff;
      if (!on_b) begin
         leds_in = LEDS_OFF;
      end else if (step_gap >= {{(TIME_W - PERIOD_W){1'b0}}, period_b}) begin
         last_step_in = time_in;
         unique case (scheme_b)
            SCHEME_TOGGLE: leds_in = leds_b ^ LEDS_ALL;
            SCHEME_CHASE: begin
               leds_in  = LED_W'(1) << phase_b;
               phase_in = phase_b + 1'b1;
            end
            default: begin
               if (phase_b == '0) begin
                  leds_in  = LEDS_PAIR_A;
                  phase_in = PHASE_W'(1);
               end else begin
                  leds_in  = LEDS_PAIR_B;
                  phase_in = '0;
               end
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= '0;
         last_step_ff <= '0;
         scheme_ff    <= SCHEME_TOGGLE;
         phase_ff     <= '0;
         on_ff        <= 1'b1;
         period_ff    <= PERIOD_RST;
         leds_ff      <= LEDS_OFF;
      end else if (s1_fire) begin
         time_ff      <= time_in;
         last_step_ff <= last_step_in;
         scheme_ff    <= scheme_in;
         phase_ff     <= phase_in;
         on_ff        <= on_in;
         period_ff    <= period_in;
         leds_ff      <= leds_in;
      end
   end

   // Stage and output valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_fire) begin
            out_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_data;
      end
      if (s1_fire) begin
         out_item_ff.leds      <= leds_in;
         out_item_ff.enabled   <= on_in;
         out_item_ff.scheme    <= scheme_in;
         out_item_ff.period_ms <= period_in;
      end
   end

`ifndef ASSERT_OFF
   a_off_means_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.enabled) |-> (rsp_data.leds == LEDS_OFF))
      else $error("LEDs lit while blinking disabled");
   a_scheme_range: assert property (@(posedge clock) disable iff (reset)
      scheme_ff <= SCHEME_LAST)
      else $error("scheme out of range");
   a_pairs_phase: assert property (@(posedge clock) disable iff (reset)
      (scheme_ff == SCHEME_PAIRS) |-> (phase_ff[1] == 1'b0))
      else $error("pairs scheme with chase phase");
   a_take_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_vld_ff)
      else $error("accepted transaction lost");
   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid)
      else $error("evaluated transaction not offered");
`endif

endmodule

/* tb/tb_led_pattern_blinker_with_buttons_top.sv */
`timescale 1ns / 1ps

module tb_led_pattern_blinker_with_buttons_top;
   import lpb_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int NUM_PINS      = 16;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 3000;
   localparam int MAX_REPORTS   = 40;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_item_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_item_type         rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // Blinker state as the testbench sees it
   logic [TIME_W-1:0]   model_time;
   logic [TIME_W-1:0]   model_last_step;
   logic [TIME_W-1:0]   model_press [NUM_PINS];
   logic [SCHEME_W-1:0] model_scheme;
   logic [PHASE_W-1:0]  model_phase;
   logic                model_on;
   logic [PERIOD_W-1:0] model_period;
   logic [LED_W-1:0]    model_leds;

   // Register copies
   logic [LOCK_W-1:0]   cfg_lockout;
   logic [PERIOD_W-1:0] cfg_period_min;
   logic [PERIOD_W-1:0] cfg_period_max;
   logic [PERIOD_W-1:0] cfg_period_step;

   rsp_item_type pending_status_q [$];
   rsp_item_type oldest_status;

   bit send_idle   = 1'b0;
   bit recv_idle   = 1'b0;
   int hold_cycles = 0;

   int events_accepted  = 0;
   int status_checked   = 0;
   int mismatch_count   = 0;
   int presses_taken    = 0;
   int pattern_steps    = 0;
   int settings_written = 0;

   led_pattern_blinker_with_buttons_top #(
      .NUM_PINS (NUM_PINS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   function automatic void reset_blinker_model();
      model_time      = '0;
      model_last_step = '0;
      for (int p = 0; p < NUM_PINS; p++) model_press[p] = '0;
      model_scheme    = SCHEME_TOGGLE;
      model_phase     = '0;
      model_on        = 1'b1;
      model_period    = PERIOD_RST;
      model_leds      = LEDS_OFF;
      cfg_lockout     = LOCKOUT_RST;
      cfg_period_min  = PERIOD_MIN_RST;
      cfg_period_max  = PERIOD_MAX_RST;
      cfg_period_step = PERIOD_STEP_RST;
   endfunction

   // Applies one tick or button event, then the blink stage; returns the status
   function automatic rsp_item_type advance_blinker(input req_item_type item);
      rsp_item_type      status;
      logic [TIME_W-1:0] since;
      int                next_period;

      if (item.req_type == REQ_TICK) begin
         model_time = model_time + 1'b1;
      end else if (int'(item.pin) < NUM_PINS) begin
         since = model_time - model_press[item.pin];
         // lockout: events too soon after the pin's last accepted one are dropped
         if (since >= TIME_W'(cfg_lockout)) begin
            model_press[item.pin] = model_time;
            presses_taken++;
            case (item.pin)
               PIN_PREV: begin
                  model_scheme = (model_scheme == SCHEME_TOGGLE) ? SCHEME_LAST
                                                                  : model_scheme - 1'b1;
                  model_phase  = '0;
                  model_leds   = LEDS_OFF;
               end
               PIN_NEXT: begin
                  model_scheme = (model_scheme == SCHEME_LAST) ? SCHEME_TOGGLE
                                                                : model_scheme + 1'b1;
                  model_phase  = '0;
                  model_leds   = LEDS_OFF;
               end
               PIN_FASTER: begin
                  if (model_period > cfg_period_min) begin
                     next_period = (model_period > cfg_period_step)
                                   ? int'(model_period) - int'(cfg_period_step) : 0;
                     if (next_period < int'(cfg_period_min))
                        next_period = int'(cfg_period_min);
                     model_period = PERIOD_W'(next_period);
                  end
               end
               PIN_SLOWER: begin
                  if (model_period < cfg_period_max) begin
                     next_period = int'(model_period) + int'(cfg_period_step);
                     if (next_period > int'(cfg_period_max))
                        next_period = int'(cfg_period_max);
                     model_period = PERIOD_W'(next_period);
                  end
               end
               PIN_ONOFF: begin
                  model_on = ~model_on;
                  if (!model_on) model_leds = LEDS_OFF;
               end
               default: ;
            endcase
         end
      end

      // blink stage, once per transaction
      since = model_time - model_last_step;
      if (!model_on) begin
         model_leds = LEDS_OFF;
      end else if (since >= TIME_W'(model_period)) begin
         model_last_step = model_time;
         pattern_steps++;
         case (model_scheme)
            SCHEME_TOGGLE: model_leds = model_leds ^ LEDS_ALL;
            SCHEME_CHASE: begin
               model_leds  = LED_W'(1) << model_phase;
               model_phase = model_phase + 1'b1;
            end
            default: begin
               if (model_phase == '0) begin
                  model_leds  = LEDS_PAIR_A;
                  model_phase = PHASE_W'(1);
               end else begin
                  model_leds  = LEDS_PAIR_B;
                  model_phase = '0;
               end
            end
         endcase
      end

      status.leds      = model_leds;
      status.enabled   = model_on;
      status.scheme    = model_scheme;
      status.period_ms = model_period;
      return status;
   endfunction

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("[%0t] mismatch on status %0d: %s got %0d, expected %0d",
                  $realtime, status_checked, what, got, want);
   endtask

   // Predict on each accepted event, compare each accepted status
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_status_q.push_back(advance_blinker(req_data));
            events_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_status_q.size() == 0) begin
               report_mismatch("status with nothing pending", int'(rsp_data), 0);
            end else begin
               oldest_status = pending_status_q.pop_front();
               if (rsp_data.leds !== oldest_status.leds)
                  report_mismatch("leds", int'(rsp_data.leds), int'(oldest_status.leds));
               if (rsp_data.enabled !== oldest_status.enabled)
                  report_mismatch("enabled", int'(rsp_data.enabled),
                                  int'(oldest_status.enabled));
               if (rsp_data.scheme !== oldest_status.scheme)
                  report_mismatch("scheme", int'(rsp_data.scheme), int'(oldest_status.scheme));
               if (rsp_data.period_ms !== oldest_status.period_ms)
                  report_mismatch("period_ms", int'(rsp_data.period_ms),
                                  int'(oldest_status.period_ms));
               status_checked++;
            end
         end
      end
   end

   // Watchdog: too long without any transaction means the block has hung
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) break;
      end
      $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------
   // Result side: random stalls, plus one long hold when asked
   // ---------------------------------------------------------------

   initial begin : status_sink
      int wait_cycles;
      forever begin
         wait_cycles = recv_idle ? $urandom_range(0, 19) : 0;
         if (hold_cycles > 0) begin
            wait_cycles = hold_cycles;
            hold_cycles = 0;
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------
   // Event side
   // ---------------------------------------------------------------

   task automatic send_item(input req_item_type item);
      int gap;
      gap = send_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_ticks(input int count);
      req_item_type item;
      for (int n = 0; n < count; n++) begin
         item.req_type = REQ_TICK;
         item.pin      = PIN_W'($urandom_range(0, 15));
         send_item(item);
      end
   endtask

   task automatic press_pin(input logic [PIN_W-1:0] pin);
      req_item_type item;
      item.req_type = REQ_BUTTON;
      item.pin      = pin;
      send_item(item);
   endtask

   // Mostly ticks, buttons biased towards the function pins
   function automatic req_item_type random_event(input int tick_pct);
      req_item_type     item;
      logic [PIN_W-1:0] fn_pins [5];
      fn_pins  = '{PIN_PREV, PIN_NEXT, PIN_FASTER, PIN_SLOWER, PIN_ONOFF};
      item.pin = PIN_W'($urandom_range(0, 15));
      if ($urandom_range(0, 99) < tick_pct) begin
         item.req_type = REQ_TICK;
      end else begin
         item.req_type = REQ_BUTTON;
         if ($urandom_range(0, 3) != 0) item.pin = fn_pins[$urandom_range(0, 4)];
      end
      return item;
   endfunction

   // Stop offering, wait for every status, then let the pipeline empty
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_status_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers back to back; only while idle
   task automatic write_settings(input logic [CSR_DAT_W-1:0] lockout,
                                 input logic [CSR_DAT_W-1:0] period_min,
                                 input logic [CSR_DAT_W-1:0] period_max,
                                 input logic [CSR_DAT_W-1:0] period_step);
      logic [CSR_IDX_W-1:0] indexes [4];
      logic [CSR_DAT_W-1:0] values  [4];
      indexes = '{CSR_LOCKOUT, CSR_PERIOD_MIN, CSR_PERIOD_MAX, CSR_PERIOD_STEP};
      values  = '{lockout, period_min, period_max, period_step};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= indexes[i];
         csr_wdata <= values[i];
         @(posedge clock);
         case (indexes[i])
            CSR_LOCKOUT:     cfg_lockout     = values[i];
            CSR_PERIOD_MIN:  cfg_period_min  = values[i][PERIOD_W-1:0];
            CSR_PERIOD_MAX:  cfg_period_max  = values[i][PERIOD_W-1:0];
            CSR_PERIOD_STEP: cfg_period_step = values[i][PERIOD_W-1:0];
            default: ;
         endcase
         settings_written++;
      end
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Presses before the first lockout window has passed must be ignored
   task automatic test_early_presses();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      press_pin(PIN_NEXT);
      press_pin(PIN_PREV);
      send_ticks(1);
      press_pin(PIN_ONOFF);
      press_pin(PIN_FASTER);
      settle_pipeline();
   endtask

   // Every control, period bounds, scheme wrap both ways, on/off, plain pins
   task automatic test_directed_controls();
      write_settings(16'd0, 16'd1, 16'd1023, 16'd1023);
      press_pin(PIN_FASTER);         // down to the floor of 1
      press_pin(PIN_SLOWER);         // up to the ceiling
      press_pin(PIN_FASTER);
      send_ticks(2);
      press_pin(PIN_NEXT);           // chase
      send_ticks(5);
      press_pin(PIN_NEXT);           // alternating pairs
      send_ticks(3);
      press_pin(PIN_NEXT);           // wraps to toggle
      press_pin(PIN_PREV);           // wraps back to pairs
      press_pin(PIN_ONOFF);          // off: LEDs dark
      send_ticks(1);
      press_pin(PIN_ONOFF);          // back on
      send_ticks(1);
      press_pin(4'd0);
      press_pin(4'd5);
      settle_pipeline();
   endtask

   // Period can reach zero when the floor is written as zero: a step per event
   task automatic test_zero_period();
      write_settings(16'd0, 16'd0, 16'd1023, 16'd1023);
      press_pin(PIN_FASTER);
      send_ticks(3);
      press_pin(PIN_NEXT);
      send_ticks(4);
      press_pin(PIN_SLOWER);
      send_ticks(2);
      press_pin(PIN_FASTER);
      press_pin(PIN_FASTER);         // already at the floor
      send_ticks(3);
      settle_pipeline();
   endtask

   // Result side holds off for a long stretch while events keep coming
   task automatic test_output_backpressure();
      write_settings(16'd3, 16'd2, 16'd40, 16'd7);
      send_idle   = 1'b0;
      recv_idle   = 1'b0;
      hold_cycles = HOLD_CYCLES;
      for (int n = 0; n < 80; n++) send_item(random_event(75));
      settle_pipeline();
   endtask

   // Random event streams over several register settings and idle mixes
   task automatic test_random_phases();
      logic [CSR_DAT_W-1:0] lockout, p_min, p_max, p_step;
      int                   tick_pct;
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            5: begin
               // reset values: presses are rare and the period long
               lockout  = LOCKOUT_RST;
               p_min    = PERIOD_MIN_RST;
               p_max    = PERIOD_MAX_RST;
               p_step   = PERIOD_STEP_RST;
               tick_pct = 90;
            end
            6: begin
               // top of every register: every press stays locked out
               lockout  = 16'hFFFF;
               p_min    = 16'd1023;
               p_max    = 16'd1023;
               p_step   = 16'd1023;
               tick_pct = 70;
            end
            default: begin
               // small values, garbage above bit 9 of the period registers
               lockout  = CSR_DAT_W'($urandom_range(0, 40));
               p_min    = ($urandom_range(0, 4) == 0) ? '0
                                                      : CSR_DAT_W'($urandom_range(1, 12));
               p_max    = CSR_DAT_W'($urandom_range(1, 80));
               p_step   = CSR_DAT_W'($urandom_range(1, 30));
               p_min[CSR_DAT_W-1:PERIOD_W]  = (CSR_DAT_W - PERIOD_W)'($urandom_range(0, 63));
               p_max[CSR_DAT_W-1:PERIOD_W]  = (CSR_DAT_W - PERIOD_W)'($urandom_range(0, 63));
               p_step[CSR_DAT_W-1:PERIOD_W] = (CSR_DAT_W - PERIOD_W)'($urandom_range(0, 63));
               tick_pct = 65;
            end
         endcase
         write_settings(lockout, p_min, p_max, p_step);
         send_idle = (ph % 2) == 1;
         recv_idle = ((ph / 2) % 2) == 1;
         for (int n = 0; n < 220; n++) send_item(random_event(tick_pct));
         settle_pipeline();
      end
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------

   initial begin
      reset_blinker_model();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_early_presses();
      test_directed_controls();
      test_zero_period();
      test_output_backpressure();
      test_random_phases();

      if (pending_status_q.size() != 0)
         report_mismatch("statuses never returned", pending_status_q.size(), 0);

      $display("Run covered %0d events and %0d checked statuses over %0d register writes.",
               events_accepted, status_checked, settings_written);
      $display("%0d presses took effect, %0d pattern steps, %0d mismatches.",
               presses_taken, pattern_steps, mismatch_count);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
